@@ rtl/core/srsb_pkg.sv @@
package srsb_pkg;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_FLAGS_HI = 4'd1,
    PH_WIDTH    = 4'd2,
    PH_HEIGHT   = 4'd3,
    PH_NBLOCKS  = 4'd4,
    PH_SKIP     = 4'd5,
    PH_WORDS    = 4'd6,
    PH_BYTES    = 4'd7,
    PH_DATA     = 4'd8,
    PH_TRAILER  = 4'd9
  } phase_t;

  typedef struct packed {
    logic        write_valid;
    logic [15:0] write_address;
    logic [7:0]  pixel_value;
    logic        sprite_done;
  } result_t;

  // Bounds of the stream encoding, used to size the running address.
  localparam int ROW_SPAN      = 1280;
  localparam int POS_SPAN      = 1024;
  localparam int ROW_ADVANCE   = 255 * (255 + 4 * 255 + 255);

endpackage

@@ rtl/core/srsb_parse.sv @@
module srsb_parse #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 200
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic [7:0]              sprite_byte,
  input  logic                    sprite_start,
  input  logic signed [10:0]      pos_x,
  input  logic signed [10:0]      pos_y,
  output srsb_pkg::result_t       res
);
  import srsb_pkg::*;

  localparam int CUR_MAG = ROW_SPAN * SCREEN_WIDTH + POS_SPAN + ROW_ADVANCE;
  localparam int CUR_W   = $clog2(CUR_MAG + 1) + 1;
  localparam int AREA    = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AREA_W  = $clog2(AREA + 1);
  localparam int CMP_W   = ((AREA_W > CUR_W) ? AREA_W : CUR_W) + 1;
  localparam logic signed [CUR_W-1:0] WIDTH_S = CUR_W'(SCREEN_WIDTH);

  phase_t                   phase, phase_next;
  logic [7:0]               rows_left, rows_left_next;
  logic [7:0]               blocks_left, blocks_left_next;
  logic [7:0]               words_held, words_held_next;
  logic [10:0]              data_left, data_left_next;
  logic signed [CUR_W-1:0]  line_cursor, line_cursor_next;
  logic signed [11:0]       current_row, current_row_next;
  logic signed [10:0]       origin_x, origin_x_next;
  logic                     row_visible, row_visible_next;
  logic                     block_visible, block_visible_next;

  logic [7:0]               rows_dec;
  logic [7:0]               blocks_dec;
  logic [10:0]              data_dec;
  logic [10:0]              block_size;
  logic signed [CUR_W-1:0]  row_ext;
  logic signed [CUR_W-1:0]  x_ext;
  logic signed [CUR_W-1:0]  cursor_base;
  logic                     row_on;
  logic                     block_on;
  logic [CMP_W-1:0]         block_end;

  assign rows_dec    = rows_left - 8'd1;
  assign blocks_dec  = blocks_left - 8'd1;
  assign data_dec    = data_left - 11'd1;
  assign block_size  = 11'({words_held, 2'b00}) + 11'(sprite_byte);
  assign row_ext     = {{(CUR_W-12){current_row[11]}}, current_row};
  assign x_ext       = {{(CUR_W-11){origin_x[10]}}, origin_x};
  assign cursor_base = row_ext * WIDTH_S + x_ext;
  assign row_on      = !current_row[11] && ({1'b0, current_row} < 13'(SCREEN_HEIGHT));
  assign block_end   = {{(CMP_W-CUR_W){1'b0}}, line_cursor} + CMP_W'(block_size);
  assign block_on    = row_visible && !line_cursor[CUR_W-1] && (block_end <= CMP_W'(AREA));

  always_comb begin
    phase_next         = phase;
    rows_left_next     = rows_left;
    blocks_left_next   = blocks_left;
    words_held_next    = words_held;
    data_left_next     = data_left;
    line_cursor_next   = line_cursor;
    current_row_next   = current_row;
    origin_x_next      = origin_x;
    row_visible_next   = row_visible;
    block_visible_next = block_visible;
    if (sprite_start) begin
      origin_x_next    = pos_x;
      current_row_next = {pos_y[10], pos_y};
      phase_next       = PH_FLAGS_HI;
    end else begin
      case (phase)
        PH_FLAGS_HI: phase_next = PH_WIDTH;
        PH_WIDTH:    phase_next = PH_HEIGHT;
        PH_HEIGHT: begin
          rows_left_next   = sprite_byte;
          current_row_next = current_row - $signed({4'b0000, sprite_byte});
          phase_next       = (sprite_byte == 8'd0) ? PH_IDLE : PH_NBLOCKS;
        end
        PH_NBLOCKS: begin
          row_visible_next = row_on;
          line_cursor_next = cursor_base;
          blocks_left_next = sprite_byte;
          phase_next       = (sprite_byte == 8'd0) ? PH_TRAILER : PH_SKIP;
        end
        PH_SKIP: begin
          line_cursor_next = line_cursor + $signed({{(CUR_W-8){1'b0}}, sprite_byte});
          phase_next       = PH_WORDS;
        end
        PH_WORDS: begin
          words_held_next = sprite_byte;
          phase_next      = PH_BYTES;
        end
        PH_BYTES: begin
          block_visible_next = block_on;
          data_left_next     = block_size;
          if (block_size != 11'd0) begin
            phase_next = PH_DATA;
          end else begin
            blocks_left_next = blocks_dec;
            phase_next       = (blocks_dec == 8'd0) ? PH_TRAILER : PH_SKIP;
          end
        end
        PH_DATA: begin
          line_cursor_next = line_cursor + CUR_W'(1);
          data_left_next   = data_dec;
          if (data_dec == 11'd0) begin
            blocks_left_next = blocks_dec;
            phase_next       = (blocks_dec == 8'd0) ? PH_TRAILER : PH_SKIP;
          end
        end
        PH_TRAILER: begin
          rows_left_next   = rows_dec;
          current_row_next = current_row + 12'sd1;
          phase_next       = (rows_dec == 8'd0) ? PH_IDLE : PH_NBLOCKS;
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    res = '0;
    if (!sprite_start) begin
      if (phase == PH_DATA && block_visible) begin
        res.write_valid   = 1'b1;
        res.write_address = line_cursor[15:0];
        res.pixel_value   = sprite_byte;
      end
      if ((phase == PH_HEIGHT && sprite_byte == 8'd0) ||
          (phase == PH_TRAILER && rows_dec == 8'd0)) begin
        res.sprite_done = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      rows_left     <= '0;
      blocks_left   <= '0;
      words_held    <= '0;
      data_left     <= '0;
      line_cursor   <= '0;
      current_row   <= '0;
      origin_x      <= '0;
      row_visible   <= 1'b0;
      block_visible <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      rows_left     <= rows_left_next;
      blocks_left   <= blocks_left_next;
      words_held    <= words_held_next;
      data_left     <= data_left_next;
      line_cursor   <= line_cursor_next;
      current_row   <= current_row_next;
      origin_x      <= origin_x_next;
      row_visible   <= row_visible_next;
      block_visible <= block_visible_next;
    end
  end

endmodule

@@ rtl/core/skip_run_sprite_blitter.sv @@
// Run-length transparent sprite blitter. Feed the encoded sprite one byte per
// transaction, with sprite_start and the draw position on the first flags byte.
// Every input byte yields exactly one registered result, so the block sustains
// one byte per clock unless the output stalls: the parser state advances on each
// accepted byte and the row start address is one multiply-add at the block-count
// byte. Results pass through a two-entry output register, so one more byte is
// taken while a result waits; in_ready drops only when both entries are full.
module skip_run_sprite_blitter #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 200
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         sprite_byte,
  input  logic               sprite_start,
  input  logic signed [10:0] pos_x,
  input  logic signed [10:0] pos_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               write_valid,
  output logic [15:0]        write_address,
  output logic [7:0]         pixel_value,
  output logic               sprite_done
);
  import srsb_pkg::*;

  logic    accept;
  result_t step_res;
  result_t out_res;
  result_t skid_res;
  logic    skid_valid;

  assign in_ready = !skid_valid;
  assign accept   = in_valid && in_ready;

  srsb_parse #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_parse (
    .clk          (clk),
    .rst          (rst),
    .step         (accept),
    .sprite_byte  (sprite_byte),
    .sprite_start (sprite_start),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .res          (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_res    <= skid_res;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
        if (accept) begin
          out_res <= step_res;
        end
      end
    end else if (accept) begin
      skid_res   <= step_res;
      skid_valid <= 1'b1;
    end
  end

  assign write_valid   = out_res.write_valid;
  assign write_address = out_res.write_address;
  assign pixel_value   = out_res.pixel_value;
  assign sprite_done   = out_res.sprite_done;

endmodule

@@ dv/skip_run_sprite_blitter_tb.sv @@
module skip_run_sprite_blitter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srsb_pkg::*;

  localparam int SCREEN_W = 320;
  localparam int SCREEN_H = 200;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         sprite_byte;
  logic               sprite_start;
  logic signed [10:0] pos_x;
  logic signed [10:0] pos_y;
  logic               out_valid;
  logic               out_ready;
  logic               write_valid;
  logic [15:0]        write_address;
  logic [7:0]         pixel_value;
  logic               sprite_done;

  skip_run_sprite_blitter #(
    .SCREEN_WIDTH (SCREEN_W),
    .SCREEN_HEIGHT(SCREEN_H)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sprite_byte  (sprite_byte),
    .sprite_start (sprite_start),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .write_valid  (write_valid),
    .write_address(write_address),
    .pixel_value  (pixel_value),
    .sprite_done  (sprite_done)
  );

  always #6 clk = ~clk;

  // Parser state mirrored by the predictor.
  phase_t     ph = PH_IDLE;
  logic [7:0] rows_remaining = '0;
  logic [7:0] blocks_remaining = '0;
  logic [7:0] word_count = '0;
  logic [10:0] pixels_remaining = '0;
  int         cursor = 0;
  int         screen_row = 0;
  int         sprite_x = 0;
  bit         row_on_screen = 1'b0;
  bit         block_on_screen = 1'b0;

  result_t    expected_writes[$];
  logic [7:0] stream[$];

  int send_gap_max = 0;
  int recv_stall_max = 0;
  int hold_request = 0;
  int errors = 0;
  int items_sent = 0;
  int writes_seen = 0;
  int sprites_done = 0;

  function automatic void close_block();
    blocks_remaining = blocks_remaining - 8'd1;
    ph = (blocks_remaining == 8'd0) ? PH_TRAILER : PH_SKIP;
  endfunction

  function automatic result_t predict_write(input logic [7:0] b, input logic start,
                                            input logic signed [10:0] px,
                                            input logic signed [10:0] py);
    result_t r;
    int      size;
    r = '0;
    if (start) begin
      sprite_x   = int'(px);
      screen_row = int'(py);
      ph         = PH_FLAGS_HI;
    end else begin
      case (ph)
        PH_FLAGS_HI: ph = PH_WIDTH;
        PH_WIDTH:    ph = PH_HEIGHT;
        PH_HEIGHT: begin
          rows_remaining = b;
          screen_row = screen_row - int'(b);
          if (b == 8'd0) begin
            r.sprite_done = 1'b1;
            ph = PH_IDLE;
          end else begin
            ph = PH_NBLOCKS;
          end
        end
        PH_NBLOCKS: begin
          row_on_screen = screen_row >= 0 && screen_row < SCREEN_H;
          cursor = screen_row * SCREEN_W + sprite_x;
          blocks_remaining = b;
          ph = (b == 8'd0) ? PH_TRAILER : PH_SKIP;
        end
        PH_SKIP: begin
          cursor = cursor + int'(b);
          ph = PH_WORDS;
        end
        PH_WORDS: begin
          word_count = b;
          ph = PH_BYTES;
        end
        PH_BYTES: begin
          size = int'(word_count) * 4 + int'(b);
          block_on_screen = row_on_screen && cursor >= 0 &&
                            cursor + size <= SCREEN_W * SCREEN_H;
          pixels_remaining = 11'(size);
          if (size > 0) ph = PH_DATA;
          else close_block();
        end
        PH_DATA: begin
          if (block_on_screen) begin
            r.write_valid   = 1'b1;
            r.write_address = 16'(cursor);
            r.pixel_value   = b;
          end
          cursor = cursor + 1;
          pixels_remaining = pixels_remaining - 11'd1;
          if (pixels_remaining == 11'd0) close_block();
        end
        PH_TRAILER: begin
          rows_remaining = rows_remaining - 8'd1;
          screen_row = screen_row + 1;
          if (rows_remaining == 8'd0) begin
            r.sprite_done = 1'b1;
            ph = PH_IDLE;
          end else begin
            ph = PH_NBLOCKS;
          end
        end
        default: ph = PH_IDLE;
      endcase
    end
    return r;
  endfunction

  function automatic int draw_idle_limit();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 2;
      default: return 6;
    endcase
  endfunction

  // Encode a random sprite into the stream queue.
  function automatic void build_sprite(input int height, input int block_pct,
                                       input int max_blocks, input int max_skip,
                                       input int max_words, input int max_bytes);
    int nblk;
    int words;
    int nbytes;
    stream.delete();
    stream.push_back(8'($urandom));
    stream.push_back(8'($urandom));
    stream.push_back(8'($urandom));
    stream.push_back(8'(height));
    for (int r = 0; r < height; r++) begin
      nblk = ($urandom_range(0, 99) < block_pct) ? $urandom_range(1, max_blocks) : 0;
      stream.push_back(8'(nblk));
      repeat (nblk) begin
        words  = $urandom_range(0, max_words);
        nbytes = $urandom_range(0, max_bytes);
        stream.push_back(8'($urandom_range(0, max_skip)));
        stream.push_back(8'(words));
        stream.push_back(8'(nbytes));
        repeat (words * 4 + nbytes) stream.push_back(8'($urandom));
      end
      stream.push_back(8'($urandom));
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic start,
                           input logic signed [10:0] px, input logic signed [10:0] py);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    sprite_byte  <= b;
    sprite_start <= start;
    pos_x        <= px;
    pos_y        <= py;
    do @(posedge clk); while (!in_ready);
    expected_writes.push_back(predict_write(b, start, px, py));
    items_sent++;
  endtask

  task automatic send_stream(input logic signed [10:0] px, input logic signed [10:0] py);
    foreach (stream[i]) begin
      if (i == 0) send_byte(stream[i], 1'b1, px, py);
      else send_byte(stream[i], 1'b0, 11'($urandom), 11'($urandom));
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_writes.size() != 0) @(posedge clk);
  endtask

  task automatic test_idle_bytes();
    send_byte(8'hff, 1'b0, 11'($urandom), 11'($urandom));
    send_byte(8'h00, 1'b0, 11'($urandom), 11'($urandom));
  endtask

  // Bottom-right corner: empty block, block ending exactly at the screen end,
  // block one pixel past it.
  task automatic test_screen_edge();
    stream = '{8'h12, 8'h34, 8'h02, 8'h01, 8'h03,
               8'h00, 8'h00, 8'h00,
               8'h00, 8'h00, 8'h02, 8'hff, 8'h00,
               8'h00, 8'h00, 8'h01, 8'h80,
               8'hc3};
    send_stream(11'sd318, 11'sd200);
  endtask

  // Off-screen row with maximal counts, cut short by a zero-height sprite.
  task automatic test_restart_offscreen();
    stream = '{8'h00, 8'hff, 8'hff, 8'hff, 8'h01, 8'hff, 8'hff, 8'hff, 8'h55, 8'haa};
    send_stream(11'sd1023, 11'sd1023);
    stream = '{8'hff, 8'h00, 8'h00, 8'h00};
    send_stream(11'sh400, 11'sh400);
  endtask

  task automatic test_tall_sprite();
    send_gap_max   = 2;
    recv_stall_max = 2;
    build_sprite(255, 10, 1, 40, 0, 3);
    send_stream(11'sd100, 11'sd230);
  endtask

  task automatic test_backpressure();
    drain_results();
    hold_request   = 150;
    send_gap_max   = 0;
    recv_stall_max = 0;
    build_sprite(4, 100, 3, 10, 3, 6);
    send_stream(11'sd20, 11'sd100);
    drain_results();
  endtask

  task automatic test_random_sprites(input int target);
    int                 counted;
    int                 cut;
    bit                 broken;
    logic signed [10:0] px;
    logic signed [10:0] py;
    counted = 0;
    while (counted < target) begin
      send_gap_max   = draw_idle_limit();
      recv_stall_max = draw_idle_limit();
      if ($urandom_range(0, 24) == 0) build_sprite(1, 100, 1, 255, 40, 255);
      else build_sprite($urandom_range(0, 8), 80, 3, 20, 3, 6);
      if ($urandom_range(0, 3) == 0) begin
        px = 11'($urandom);
        py = 11'($urandom);
      end else begin
        px = 11'($urandom_range(0, 400) - 40);
        py = 11'($urandom_range(0, 260) - 20);
      end
      broken = 1'b0;
      if ($urandom_range(0, 9) == 0 && stream.size() > 1) begin
        cut = $urandom_range(1, stream.size() - 1);
        stream = stream[0:cut-1];
        broken = 1'b1;
      end
      send_stream(px, py);
      counted += stream.size();
      if (!broken && $urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 11'($urandom),
                                                11'($urandom));
      end
      if ($urandom_range(0, 7) == 0) drain_results();
    end
  endtask

  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end else begin
        stall = $urandom_range(0, recv_stall_max);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && !rst));
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_writes.size() == 0) begin
        $error("result with no transaction pending");
        errors++;
      end else begin
        want = expected_writes.pop_front();
        if (write_valid !== want.write_valid) begin
          $error("write_valid: expected %0d, got %0d", want.write_valid, write_valid);
          errors++;
        end
        if (write_address !== want.write_address) begin
          $error("write_address: expected %0d, got %0d", want.write_address, write_address);
          errors++;
        end
        if (pixel_value !== want.pixel_value) begin
          $error("pixel_value: expected 0x%0h, got 0x%0h", want.pixel_value, pixel_value);
          errors++;
        end
        if (sprite_done !== want.sprite_done) begin
          $error("sprite_done: expected %0d, got %0d", want.sprite_done, sprite_done);
          errors++;
        end
      end
      if (write_valid === 1'b1) writes_seen++;
      if (sprite_done === 1'b1) sprites_done++;
    end
  end

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    sprite_byte  = '0;
    sprite_start = 1'b0;
    pos_x        = '0;
    pos_y        = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    send_gap_max   = 6;
    recv_stall_max = 6;
    test_idle_bytes();
    test_screen_edge();
    test_restart_offscreen();
    test_tall_sprite();
    test_backpressure();
    test_random_sprites(520);

    drain_results();
    repeat (10) @(posedge clk);
    if (expected_writes.size() != 0) begin
      $error("%0d results never arrived", expected_writes.size());
      errors++;
    end
    $display("Sent %0d bytes; saw %0d pixel writes and %0d finished sprites.",
             items_sent, writes_seen, sprites_done);
    $display("Stimulus mixed restarts, clipped rows and blocks, idle noise and stalls.");
    if (errors == 0) begin
      $display("skip_run_sprite_blitter: match");
    end else begin
      $display("skip_run_sprite_blitter: mismatch");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("skip_run_sprite_blitter: mismatch");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/srsb_pkg.sv
rtl/core/srsb_parse.sv
rtl/core/skip_run_sprite_blitter.sv
dv/skip_run_sprite_blitter_tb.sv
